>>> rtl/core/tte_pkg.sv
// Shared types, character codes and calendar constants for the timestamp parser.
package tte_pkg;

  // Parser phases after the fixed date and time fields
  localparam logic [3:0] PH_FIXED     = 4'd0;
  localparam logic [3:0] PH_AFTER_SEC = 4'd1;
  localparam logic [3:0] PH_FRAC_NEED = 4'd2;
  localparam logic [3:0] PH_FRAC_MORE = 4'd3;
  localparam logic [3:0] PH_OFF_H1    = 4'd4;
  localparam logic [3:0] PH_OFF_H2    = 4'd5;
  localparam logic [3:0] PH_OFF_COLON = 4'd6;
  localparam logic [3:0] PH_OFF_M1    = 4'd7;
  localparam logic [3:0] PH_OFF_M2    = 4'd8;
  localparam logic [3:0] PH_DONE      = 4'd9;

  // ASCII codes
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_T_UC     = 8'h54;
  localparam logic [7:0] CH_T_LC     = 8'h74;
  localparam logic [7:0] CH_Z_UC     = 8'h5A;
  localparam logic [7:0] CH_Z_LC     = 8'h7A;

  // Calendar and time constants
  localparam logic [26:0] MS_PER_DAY    = 27'd86400000;
  localparam logic [26:0] MS_PER_HOUR   = 27'd3600000;
  localparam logic [26:0] MS_PER_MIN    = 27'd60000;
  localparam logic [26:0] MS_PER_SEC    = 27'd1000;
  localparam logic [17:0] DAYS_PER_ERA  = 18'd146097;
  localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
  localparam logic [19:0] EPOCH_DAYS    = 20'd719468;

  // Reciprocals for division of small values by constants
  localparam logic [13:0] RECIP_400     = 14'd10486;  // 2^22 / 400, rounded up
  localparam int          RECIP_400_SH  = 22;
  localparam logic [6:0]  RECIP_100     = 7'd82;      // 2^13 / 100, rounded up
  localparam int          RECIP_100_SH  = 13;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_PREP,
    STEP_ERA,
    STEP_YOE,
    STEP_C100,
    STEP_DOE,
    STEP_DAYS,
    STEP_M_DAYS,
    STEP_M_HOUR,
    STEP_M_MIN,
    STEP_M_SEC,
    STEP_M_FRAC,
    STEP_M_OFF
  } step_e;

  typedef struct packed {
    logic  parse_en;
    logic  clear;
    logic  load;
    step_e step;
  } cmd_t;

  // Day of year for the start of a March-based month index
  function automatic logic [8:0] doy_base(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/tte_ctrl.sv
// Controller: byte acceptance, conversion sequence and output handshake.
module tte_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          byte_present_i,
  input  logic          last_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tte_pkg::cmd_t cmd_o
);

  localparam logic [3:0] ST_PARSE  = 4'd0;
  localparam logic [3:0] ST_PREP   = 4'd1;
  localparam logic [3:0] ST_ERA    = 4'd2;
  localparam logic [3:0] ST_YOE    = 4'd3;
  localparam logic [3:0] ST_C100   = 4'd4;
  localparam logic [3:0] ST_DOE    = 4'd5;
  localparam logic [3:0] ST_DAYS   = 4'd6;
  localparam logic [3:0] ST_M_DAYS = 4'd7;
  localparam logic [3:0] ST_M_HOUR = 4'd8;
  localparam logic [3:0] ST_M_MIN  = 4'd9;
  localparam logic [3:0] ST_M_SEC  = 4'd10;
  localparam logic [3:0] ST_M_FRAC = 4'd11;
  localparam logic [3:0] ST_M_OFF  = 4'd12;
  localparam logic [3:0] ST_LOAD   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_accept;
  logic       out_free;

  assign in_accept = in_valid_i && (state_q == ST_PARSE);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d           = state_q;
    cmd_o.parse_en    = 1'b0;
    cmd_o.clear       = 1'b0;
    cmd_o.load        = 1'b0;
    cmd_o.step        = tte_pkg::STEP_NONE;
    unique case (state_q)
      ST_PARSE: begin
        cmd_o.parse_en = in_accept && byte_present_i;
        if (in_accept && last_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.step = tte_pkg::STEP_PREP;
        state_d    = ST_ERA;
      end
      ST_ERA: begin
        cmd_o.step = tte_pkg::STEP_ERA;
        state_d    = ST_YOE;
      end
      ST_YOE: begin
        cmd_o.step = tte_pkg::STEP_YOE;
        state_d    = ST_C100;
      end
      ST_C100: begin
        cmd_o.step = tte_pkg::STEP_C100;
        state_d    = ST_DOE;
      end
      ST_DOE: begin
        cmd_o.step = tte_pkg::STEP_DOE;
        state_d    = ST_DAYS;
      end
      ST_DAYS: begin
        cmd_o.step = tte_pkg::STEP_DAYS;
        state_d    = ST_M_DAYS;
      end
      ST_M_DAYS: begin
        cmd_o.step = tte_pkg::STEP_M_DAYS;
        state_d    = ST_M_HOUR;
      end
      ST_M_HOUR: begin
        cmd_o.step = tte_pkg::STEP_M_HOUR;
        state_d    = ST_M_MIN;
      end
      ST_M_MIN: begin
        cmd_o.step = tte_pkg::STEP_M_MIN;
        state_d    = ST_M_SEC;
      end
      ST_M_SEC: begin
        cmd_o.step = tte_pkg::STEP_M_SEC;
        state_d    = ST_M_FRAC;
      end
      ST_M_FRAC: begin
        cmd_o.step = tte_pkg::STEP_M_FRAC;
        state_d    = ST_M_OFF;
      end
      ST_M_OFF: begin
        cmd_o.step = tte_pkg::STEP_M_OFF;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd_o.load  = 1'b1;
          cmd_o.clear = 1'b1;
          state_d     = ST_PARSE;
        end
      end
      default: state_d = ST_PARSE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PARSE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_PARSE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/tte_dp.sv
// Datapath: byte parser registers, calendar arithmetic and result register.
module tte_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tte_pkg::cmd_t cmd_i,
  input  logic [7:0]    text_byte_i,
  output logic [63:0]   epoch_ms_o
);

  localparam int RECIP_400_SH_IDX = tte_pkg::RECIP_400_SH;
  localparam int RECIP_100_SH_IDX = tte_pkg::RECIP_100_SH;

  // Parser state
  logic [4:0]  pos_q, pos_d;
  logic [3:0]  phase_q, phase_d;
  logic        all_dig_q, all_dig_d;
  logic [63:0] num_q, num_d;
  logic        num_ovf_q, num_ovf_d;
  logic        failed_q, failed_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d;
  logic [6:0]  day_q, day_d;
  logic [6:0]  hour_q, hour_d;
  logic [6:0]  min_q, min_d;
  logic [6:0]  sec_q, sec_d;
  logic [9:0]  millis_q, millis_d;
  logic [1:0]  frac_cnt_q, frac_cnt_d;
  logic        off_neg_q, off_neg_d;
  logic [6:0]  off_hour_q, off_hour_d;
  logic [6:0]  off_min_q, off_min_d;

  // Conversion registers
  logic signed [14:0] y_q, y_d;
  logic        [8:0]  doy_q, doy_d;
  logic        [9:0]  frac_q, frac_d;
  logic signed [11:0] off_q, off_d;
  logic signed [5:0]  era_q, era_d;
  logic        [8:0]  yoe_q, yoe_d;
  logic        [1:0]  c100_q, c100_d;
  logic        [17:0] doe_q, doe_d;
  logic signed [22:0] days_q, days_d;
  logic signed [49:0] acc_q, acc_d;
  logic        [63:0] out_q, out_d;

  logic [7:0]  b;
  logic [3:0]  dg;
  logic        is_dig;
  logic        zone_z;
  logic        zone_sign;
  logic [67:0] num_next;

  logic        le_feb;
  logic [3:0]  mp;
  logic [10:0] off_mag;
  logic [27:0] era_prod;
  logic signed [14:0] era_x400;
  logic [15:0] c100_prod;
  logic signed [23:0] days_sum;
  logic signed [23:0] mac_a;
  logic        [26:0] mac_b;
  logic signed [51:0] mac_prod;
  logic        fields_ok;

  function automatic logic [13:0] dec14(input logic [13:0] v, input logic [3:0] d);
    dec14 = 14'({v, 3'b000} + {2'b00, v, 1'b0} + 17'(d));
  endfunction

  assign b         = text_byte_i;
  assign dg        = text_byte_i[3:0];
  assign is_dig    = (b >= tte_pkg::CH_ZERO) && (b <= tte_pkg::CH_NINE);
  assign zone_z    = (b == tte_pkg::CH_Z_UC) || (b == tte_pkg::CH_Z_LC);
  assign zone_sign = (b == tte_pkg::CH_PLUS) || (b == tte_pkg::CH_DASH);
  assign num_next  = 68'({num_q, 3'b000}) + 68'({num_q, 1'b0}) + 68'(dg);

  // Byte parser
  always_comb begin
    pos_d      = pos_q;
    phase_d    = phase_q;
    all_dig_d  = all_dig_q;
    num_d      = num_q;
    num_ovf_d  = num_ovf_q;
    failed_d   = failed_q;
    year_d     = year_q;
    month_d    = month_q;
    day_d      = day_q;
    hour_d     = hour_q;
    min_d      = min_q;
    sec_d      = sec_q;
    millis_d   = millis_q;
    frac_cnt_d = frac_cnt_q;
    off_neg_d  = off_neg_q;
    off_hour_d = off_hour_q;
    off_min_d  = off_min_q;
    if (cmd_i.clear) begin
      pos_d      = '0;
      phase_d    = tte_pkg::PH_FIXED;
      all_dig_d  = 1'b1;
      num_d      = '0;
      num_ovf_d  = 1'b0;
      failed_d   = 1'b0;
      year_d     = '0;
      month_d    = '0;
      day_d      = '0;
      hour_d     = '0;
      min_d      = '0;
      sec_d      = '0;
      millis_d   = '0;
      frac_cnt_d = '0;
      off_neg_d  = 1'b0;
      off_hour_d = '0;
      off_min_d  = '0;
    end else if (cmd_i.parse_en) begin
      // raw decimal number runs alongside the layout parser
      if (is_dig) begin
        if (num_next[67:64] != 4'd0) num_ovf_d = 1'b1;
        else num_d = num_next[63:0];
      end else begin
        all_dig_d = 1'b0;
      end
      if (!failed_q) begin
        unique case (phase_q)
          tte_pkg::PH_FIXED: begin
            priority if (pos_q == 5'd4 || pos_q == 5'd7) begin
              if (b != tte_pkg::CH_DASH) failed_d = 1'b1;
            end else if (pos_q == 5'd13 || pos_q == 5'd16) begin
              if (b != tte_pkg::CH_COLON) failed_d = 1'b1;
            end else if (pos_q == 5'd10) begin
              if (b != tte_pkg::CH_T_UC && b != tte_pkg::CH_T_LC) failed_d = 1'b1;
            end else if (!is_dig) begin
              failed_d = 1'b1;
            end else if (pos_q < 5'd4) begin
              year_d = dec14(year_q, dg);
            end else if (pos_q < 5'd7) begin
              month_d = 7'(dec14(14'(month_q), dg));
            end else if (pos_q < 5'd10) begin
              day_d = 7'(dec14(14'(day_q), dg));
            end else if (pos_q < 5'd13) begin
              hour_d = 7'(dec14(14'(hour_q), dg));
            end else if (pos_q < 5'd16) begin
              min_d = 7'(dec14(14'(min_q), dg));
            end else begin
              sec_d = 7'(dec14(14'(sec_q), dg));
            end
            if (pos_q == 5'd18) phase_d = tte_pkg::PH_AFTER_SEC;
          end
          tte_pkg::PH_AFTER_SEC: begin
            priority if (b == tte_pkg::CH_DOT) begin
              phase_d = tte_pkg::PH_FRAC_NEED;
            end else if (zone_z) begin
              phase_d = tte_pkg::PH_DONE;
            end else if (zone_sign) begin
              off_neg_d = (b == tte_pkg::CH_DASH);
              phase_d   = tte_pkg::PH_OFF_H1;
            end else begin
              failed_d = 1'b1;
            end
          end
          tte_pkg::PH_FRAC_NEED, tte_pkg::PH_FRAC_MORE: begin
            priority if (is_dig) begin
              // keep the first three digits only
              if (frac_cnt_q != 2'd3) begin
                millis_d   = 10'(dec14(14'(millis_q), dg));
                frac_cnt_d = frac_cnt_q + 2'd1;
              end
              phase_d = tte_pkg::PH_FRAC_MORE;
            end else if (phase_q == tte_pkg::PH_FRAC_NEED) begin
              failed_d = 1'b1;
            end else if (zone_z) begin
              phase_d = tte_pkg::PH_DONE;
            end else if (zone_sign) begin
              off_neg_d = (b == tte_pkg::CH_DASH);
              phase_d   = tte_pkg::PH_OFF_H1;
            end else begin
              failed_d = 1'b1;
            end
          end
          tte_pkg::PH_OFF_H1, tte_pkg::PH_OFF_H2: begin
            if (!is_dig) begin
              failed_d = 1'b1;
            end else begin
              off_hour_d = 7'(dec14(14'(off_hour_q), dg));
              phase_d    = phase_q + 4'd1;
            end
          end
          tte_pkg::PH_OFF_COLON: begin
            if (b != tte_pkg::CH_COLON) failed_d = 1'b1;
            else phase_d = tte_pkg::PH_OFF_M1;
          end
          tte_pkg::PH_OFF_M1, tte_pkg::PH_OFF_M2: begin
            if (!is_dig) begin
              failed_d = 1'b1;
            end else begin
              off_min_d = 7'(dec14(14'(off_min_q), dg));
              phase_d   = phase_q + 4'd1;
            end
          end
          default: failed_d = 1'b1;  // bytes after a complete zone
        endcase
      end
      if (pos_q != 5'd31) pos_d = pos_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      phase_q    <= tte_pkg::PH_FIXED;
      all_dig_q  <= 1'b1;
      num_q      <= '0;
      num_ovf_q  <= 1'b0;
      failed_q   <= 1'b0;
      year_q     <= '0;
      month_q    <= '0;
      day_q      <= '0;
      hour_q     <= '0;
      min_q      <= '0;
      sec_q      <= '0;
      millis_q   <= '0;
      frac_cnt_q <= '0;
      off_neg_q  <= 1'b0;
      off_hour_q <= '0;
      off_min_q  <= '0;
    end else begin
      pos_q      <= pos_d;
      phase_q    <= phase_d;
      all_dig_q  <= all_dig_d;
      num_q      <= num_d;
      num_ovf_q  <= num_ovf_d;
      failed_q   <= failed_d;
      year_q     <= year_d;
      month_q    <= month_d;
      day_q      <= day_d;
      hour_q     <= hour_d;
      min_q      <= min_d;
      sec_q      <= sec_d;
      millis_q   <= millis_d;
      frac_cnt_q <= frac_cnt_d;
      off_neg_q  <= off_neg_d;
      off_hour_q <= off_hour_d;
      off_min_q  <= off_min_d;
    end
  end

  // Civil date to day count, then the millisecond sum
  assign le_feb    = (month_q <= 7'd2);
  assign mp        = 4'(le_feb ? month_q + 7'd9 : month_q - 7'd3);
  assign off_mag   = 11'({off_hour_q[4:0], 6'b000000}) - 11'({off_hour_q[4:0], 2'b00})
                   + 11'(off_min_q[5:0]);
  assign era_prod  = 28'(y_q[13:0]) * 28'(tte_pkg::RECIP_400);
  assign era_x400  = 15'(era_q) * $signed(15'(tte_pkg::YEARS_PER_ERA));
  assign c100_prod = 16'(yoe_q) * 16'(tte_pkg::RECIP_100);
  assign days_sum  = 24'(era_q) * $signed(24'(tte_pkg::DAYS_PER_ERA))
                   + $signed({6'b000000, doe_q}) - $signed(24'(tte_pkg::EPOCH_DAYS));
  assign mac_prod  = mac_a * $signed({1'b0, mac_b});

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    unique case (cmd_i.step)
      tte_pkg::STEP_M_DAYS: begin
        mac_a = 24'(days_q);
        mac_b = tte_pkg::MS_PER_DAY;
      end
      tte_pkg::STEP_M_HOUR: begin
        mac_a = $signed({19'd0, hour_q[4:0]});
        mac_b = tte_pkg::MS_PER_HOUR;
      end
      tte_pkg::STEP_M_MIN: begin
        mac_a = $signed({18'd0, min_q[5:0]});
        mac_b = tte_pkg::MS_PER_MIN;
      end
      tte_pkg::STEP_M_SEC: begin
        mac_a = $signed({18'd0, sec_q[5:0]});
        mac_b = tte_pkg::MS_PER_SEC;
      end
      tte_pkg::STEP_M_FRAC: begin
        mac_a = $signed({14'd0, frac_q});
        mac_b = 27'd1;
      end
      tte_pkg::STEP_M_OFF: begin
        mac_a = 24'(off_q);
        mac_b = tte_pkg::MS_PER_MIN;
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  assign fields_ok = (month_q >= 7'd1) && (month_q <= 7'd12) &&
                     (day_q >= 7'd1) && (day_q <= 7'd31) &&
                     (hour_q <= 7'd23) && (min_q <= 7'd59) && (sec_q <= 7'd60) &&
                     (off_hour_q <= 7'd23) && (off_min_q <= 7'd59);

  always_comb begin
    y_d    = y_q;
    doy_d  = doy_q;
    frac_d = frac_q;
    off_d  = off_q;
    era_d  = era_q;
    yoe_d  = yoe_q;
    c100_d = c100_q;
    doe_d  = doe_q;
    days_d = days_q;
    acc_d  = acc_q;
    unique case (cmd_i.step)
      tte_pkg::STEP_PREP: begin
        y_d   = $signed({1'b0, year_q}) - (le_feb ? 15'sd1 : 15'sd0);
        doy_d = tte_pkg::doy_base(mp) + 9'(day_q) - 9'd1;
        // pad a short fraction to milliseconds
        unique case (frac_cnt_q)
          2'd3:    frac_d = millis_q;
          2'd2:    frac_d = 10'(14'(millis_q) * 14'd10);
          2'd1:    frac_d = 10'(14'(millis_q) * 14'd100);
          default: frac_d = '0;
        endcase
        off_d = off_neg_q ? $signed({1'b0, off_mag}) : -$signed({1'b0, off_mag});
        acc_d = '0;
      end
      tte_pkg::STEP_ERA: begin
        era_d = y_q[14] ? -6'sd1 : $signed(era_prod[27:RECIP_400_SH_IDX]);
      end
      tte_pkg::STEP_YOE:  yoe_d  = 9'(y_q - era_x400);
      tte_pkg::STEP_C100: c100_d = c100_prod[RECIP_100_SH_IDX + 1:RECIP_100_SH_IDX];
      tte_pkg::STEP_DOE: begin
        doe_d = 18'(18'(yoe_q) * 18'd365) + 18'(yoe_q[8:2]) - 18'(c100_q) + 18'(doy_q);
      end
      tte_pkg::STEP_DAYS: days_d = 23'(days_sum);
      tte_pkg::STEP_M_DAYS, tte_pkg::STEP_M_HOUR, tte_pkg::STEP_M_MIN,
      tte_pkg::STEP_M_SEC, tte_pkg::STEP_M_FRAC, tte_pkg::STEP_M_OFF: begin
        acc_d = acc_q + mac_prod[49:0];
      end
      default: acc_d = acc_q;
    endcase
  end

  // Pick the result: raw number, calendar time clamped at zero, or zero
  always_comb begin
    out_d = out_q;
    if (cmd_i.load) begin
      priority if (pos_q == 5'd0) begin
        out_d = '0;
      end else if (all_dig_q) begin
        out_d = num_ovf_q ? 64'd0 : num_q;
      end else if (failed_q || phase_q != tte_pkg::PH_DONE || !fields_ok) begin
        out_d = '0;
      end else if (acc_q[49]) begin
        out_d = '0;
      end else begin
        out_d = 64'(acc_q[48:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    doy_q  <= doy_d;
    frac_q <= frac_d;
    off_q  <= off_d;
    era_q  <= era_d;
    yoe_q  <= yoe_d;
    c100_q <= c100_d;
    doe_q  <= doe_d;
    days_q <= days_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  assign epoch_ms_o = out_q;

endmodule

>>> rtl/core/timestamp_text_to_epoch_ms.sv
// Top level of the timestamp text to Unix milliseconds converter.
//
// Input channel: one string byte per item (text_byte_i), with byte_present_i
// low marking "no byte" and last_i high on the final item of a string. An
// item with byte_present_i low and last_i low is taken and ignored; with
// last_i high it closes the string without adding a byte.
// Output channel: one item (epoch_ms_o) for every string, either the plain
// decimal value of an all-digit string, the RFC3339 time in ms since 1970
// UTC, or zero on any error.
// Throughput: one byte per cycle while a string streams in. After the item
// with last_i the parser stalls while the calendar arithmetic runs its step
// sequence (preparation, era, year of era, century, day of era, day count,
// then a shared multiply-accumulate over days, hours, minutes, seconds,
// fraction and zone offset) and then loads the result into the output
// register; a new string is taken only after that load.
// Stalls: a result waits in the output register while the next string is
// taken; if the output is still occupied when the following result is
// ready, hold the input stalled until the receiver takes it.
// Reset: asynchronous, active low; clear the parser and drop any pending
// result.
module timestamp_text_to_epoch_ms (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        byte_present_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] epoch_ms_o
);

  tte_pkg::cmd_t cmd;

  // Sequence the parse, conversion and output handshake
  tte_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .byte_present_i (byte_present_i),
    .last_i         (last_i),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cmd_o          (cmd)
  );

  // Parser registers, calendar arithmetic and the result register
  tte_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .text_byte_i (text_byte_i),
    .epoch_ms_o  (epoch_ms_o)
  );

  // A closing item starts the conversion: stall right after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> in_stall_o)
    else $error("input not stalled after closing item");

  // The input is still stalled at the last arithmetic step of the conversion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |-> ##12 in_stall_o)
    else $error("conversion ended early");

  // Bytes inside a string never stall the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !last_i) |=> !in_stall_o)
    else $error("stall inside a string");

  // A new result only shows up as the parser reopens
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(in_stall_o) && !in_stall_o))
    else $error("result without conversion");

endmodule
